@@ rtl/drr_pkg.sv @@
// shared types, codes and widths for the display resize request filter
package drr_pkg;

    localparam int DIM_BITS      = 16;
    localparam int TIME_BITS     = 48;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int PROD_BITS     = 2 * DIM_BITS;
    localparam int CNT_BITS      = $clog2(DIM_BITS);

    typedef logic [DIM_BITS-1:0]  t_dim;
    typedef logic [TIME_BITS-1:0] t_time;

    // request types
    localparam logic [1:0] REQ_RESIZE    = 2'd0;
    localparam logic [1:0] REQ_POLL      = 2'd1;
    localparam logic [1:0] REQ_RECONNECT = 2'd2;

    // result actions
    localparam logic [1:0] ACT_NONE      = 2'd0;
    localparam logic [1:0] ACT_LAYOUT    = 2'd1;
    localparam logic [1:0] ACT_RECONNECT = 2'd2;

    // resize modes
    localparam logic [1:0] MODE_LAYOUT    = 2'd1;
    localparam logic [1:0] MODE_RECONNECT = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_DIM  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_DIM  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INTERVAL = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MODE     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CONN     = 3'd4;

    // reset values of the configuration registers
    localparam t_dim        RST_MIN_DIM  = 16'd200;
    localparam t_dim        RST_MAX_DIM  = 16'd8192;
    localparam logic [15:0] RST_INTERVAL = 16'd500;
    localparam logic [1:0]  RST_MODE     = MODE_LAYOUT;

    typedef struct packed {
        logic [1:0] req_type;
        t_dim       want_width;
        t_dim       want_height;
        t_time      now_ms;
        t_dim       current_width;
        t_dim       current_height;
        logic       current_known;
    } t_in;

    typedef struct packed {
        logic [1:0] action;
        t_dim       pending_width_out;
        t_dim       pending_height_out;
        logic       reconnect_flag;
    } t_out;

    // request to the shared multiply/divide unit: mul_a * mul_b / divisor
    typedef struct packed {
        logic start;
        t_dim mul_a;
        t_dim mul_b;
        t_dim divisor;
    } t_mdu_req;

    // ovf: quotient does not fit in DIM_BITS
    typedef struct packed {
        logic done;
        logic ovf;
        t_dim quot;
    } t_mdu_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIT,
        ST_WAIT,
        ST_PEND,
        ST_TRY,
        ST_MISC
    } t_state;

    typedef enum logic [2:0] {
        MS_IDLE,
        MS_MUL,
        MS_CHK,
        MS_DIV,
        MS_DONE
    } t_mdu_state;

endpackage

@@ rtl/drr_muldiv.sv @@
// shared multiply then iterative restoring divide unit, one quotient bit per cycle
module drr_muldiv import drr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mdu_req i_req,
    output t_mdu_rsp o_rsp
);

    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(DIM_BITS - 1);

    t_mdu_state           r_state, n_state;
    t_dim                 r_opa, r_opb, r_div;
    logic [PROD_BITS-1:0] r_prod;
    t_dim                 r_rem, r_quo;
    logic                 r_ovf;
    logic [CNT_BITS-1:0]  r_cnt;

    t_dim            prod_hi, prod_lo;
    logic            hi_ovf;
    logic [DIM_BITS:0] rem_sh, rem_sub;
    logic            step_ge;
    t_dim            step_rem;

    assign prod_hi = r_prod[PROD_BITS-1:DIM_BITS];
    assign prod_lo = r_prod[DIM_BITS-1:0];
    // quotient fits DIM_BITS only when the upper half is below the divisor
    assign hi_ovf  = prod_hi >= r_div;

    // next dividend bit comes out of the top of the quotient register
    assign rem_sh   = {r_rem, r_quo[DIM_BITS-1]};
    assign rem_sub  = rem_sh - {1'b0, r_div};
    assign step_ge  = rem_sh >= {1'b0, r_div};
    assign step_rem = step_ge ? rem_sub[DIM_BITS-1:0] : rem_sh[DIM_BITS-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            MS_IDLE: begin
                if (i_req.start) begin
                    n_state = MS_MUL;
                end
            end
            MS_MUL:  n_state = MS_CHK;
            MS_CHK: begin
                n_state = hi_ovf ? MS_DONE : MS_DIV;
            end
            MS_DIV: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = MS_DONE;
                end
            end
            MS_DONE: n_state = MS_IDLE;
            default: n_state = MS_IDLE;
        endcase
    end

    always_comb begin
        o_rsp.done = (r_state == MS_DONE);
        o_rsp.ovf  = r_ovf;
        o_rsp.quot = r_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            MS_IDLE: begin
                if (i_req.start) begin
                    r_opa <= i_req.mul_a;
                    r_opb <= i_req.mul_b;
                    r_div <= i_req.divisor;
                end
            end
            MS_MUL: begin
                r_prod <= PROD_BITS'(r_opa) * PROD_BITS'(r_opb);
            end
            MS_CHK: begin
                r_ovf <= hi_ovf;
                r_rem <= prod_hi;
                r_quo <= prod_lo;
                r_cnt <= '0;
            end
            MS_DIV: begin
                r_rem <= step_rem;
                r_quo <= {r_quo[DIM_BITS-2:0], step_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

@@ rtl/display_resize_request_filter.sv @@
// top level: resize fitting sequencer, update gate and state registers
//
// Input channel i_in_valid / o_in_stall carries one request beat (resize,
// poll or reconnect complete). Output channel o_out_valid / i_out_stall
// returns exactly one result beat per request: the action taken, the
// pending size after the request and the reconnect flag.
// A resize runs up to two multiply/divide passes on one shared unit, each
// a multiply, a range check and one quotient bit per cycle; a resize
// already in range, a poll and a reconnect complete use no division.
// Configuration writes take effect at once; the user must make them only
// while idle, since the block itself does not enforce this.
// One request is worked on at a time: o_in_stall is high from accept until
// the result has been written to the output register.
// The output register holds a finished result while i_out_stall is high;
// the next request may be accepted then, but its result waits in the
// sequencer until the output register is free.
// Synchronous reset loads the register defaults, clears the pending size,
// last issue time and reconnect flag, and empties the output register.
module display_resize_request_filter import drr_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  t_in                      i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_out                     o_out_data,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    // configuration
    t_dim        r_min, r_max;
    logic [15:0] r_intv;
    logic [1:0]  r_mode;
    logic        r_conn;

    // sequencer and working copy of the request
    t_state r_state, n_state;
    t_in    r_item;
    t_dim   r_w, r_h;
    logic   r_pass;
    logic   r_low;

    // filter state
    t_dim  r_pend_w, r_pend_h;
    t_time r_last;
    logic  r_flag;

    // output register
    t_out r_out;
    logic r_ov;

    t_mdu_req mdu_req;
    t_mdu_rsp mdu_rsp;

    t_dim  fit_a, fit_b;
    logic  below, above, a_zero, div_go;
    t_dim  res_a, res_b, lo_b, hi_b;
    logic  out_free;
    t_time elapsed;
    logic  issue;
    logic [1:0] try_act;
    logic  try_flag;

    drr_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mdu_req),
        .o_rsp   (mdu_rsp)
    );

    // first pass fits the width, second pass the height
    assign fit_a  = r_pass ? r_h : r_w;
    assign fit_b  = r_pass ? r_w : r_h;
    assign below  = fit_a < r_min;
    assign above  = fit_a > r_max;
    assign a_zero = (fit_a == '0);
    assign div_go = (below && !a_zero) || above;

    // clamp the scaled dimension on the side it was pushed from
    assign lo_b  = (mdu_rsp.ovf || mdu_rsp.quot > r_max) ? r_max : mdu_rsp.quot;
    assign hi_b  = (mdu_rsp.quot < r_min) ? r_min : mdu_rsp.quot;
    assign res_a = r_low ? r_min : r_max;
    assign res_b = r_low ? lo_b : hi_b;

    assign out_free = !r_ov || !i_out_stall;

    assign elapsed = r_item.now_ms - r_last;
    assign issue   = (r_pend_w != '0) && (r_pend_h != '0)
                     && (elapsed > TIME_BITS'(r_intv))
                     && !(r_item.current_known
                          && r_pend_w == r_item.current_width
                          && r_pend_h == r_item.current_height);

    always_comb begin
        try_act = ACT_NONE;
        if (issue) begin
            if (r_mode == MODE_RECONNECT) begin
                try_act = ACT_RECONNECT;
            end else if (r_mode == MODE_LAYOUT && r_conn) begin
                try_act = ACT_LAYOUT;
            end
        end
    end
    assign try_flag = r_flag || (issue && r_mode == MODE_RECONNECT);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_data.req_type)
                        REQ_RESIZE: n_state = ST_FIT;
                        REQ_POLL:   n_state = ST_TRY;
                        default:    n_state = ST_MISC;
                    endcase
                end
            end
            ST_FIT: begin
                if (div_go) begin
                    n_state = ST_WAIT;
                end else if (r_pass) begin
                    n_state = ST_PEND;
                end
            end
            ST_WAIT: begin
                if (mdu_rsp.done) begin
                    n_state = r_pass ? ST_PEND : ST_FIT;
                end
            end
            ST_PEND: n_state = ST_TRY;
            ST_TRY, ST_MISC: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall      = (r_state != ST_IDLE);
        mdu_req.start   = (r_state == ST_FIT) && div_go;
        mdu_req.mul_a   = fit_b;
        mdu_req.mul_b   = below ? r_min : r_max;
        mdu_req.divisor = fit_a;
        o_out_valid     = r_ov;
        o_out_data      = r_out;
    end

    // control and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min    <= RST_MIN_DIM;
            r_max    <= RST_MAX_DIM;
            r_intv   <= RST_INTERVAL;
            r_mode   <= RST_MODE;
            r_conn   <= 1'b0;
            r_state  <= ST_IDLE;
            r_pend_w <= '0;
            r_pend_h <= '0;
            r_last   <= '0;
            r_flag   <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MIN_DIM:  r_min  <= i_cfg_data[DIM_BITS-1:0];
                    CFG_MAX_DIM:  r_max  <= i_cfg_data[DIM_BITS-1:0];
                    CFG_INTERVAL: r_intv <= i_cfg_data[15:0];
                    CFG_MODE:     r_mode <= i_cfg_data[1:0];
                    CFG_CONN:     r_conn <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if ((r_state == ST_TRY || r_state == ST_MISC) && out_free) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                ST_PEND: begin
                    // an odd width is lowered to even
                    r_pend_w <= {r_w[DIM_BITS-1:1], 1'b0};
                    r_pend_h <= r_h;
                end
                ST_TRY: begin
                    if (out_free) begin
                        r_flag <= try_flag;
                        if (issue) begin
                            r_last <= r_item.now_ms;
                        end
                    end
                end
                ST_MISC: begin
                    if (out_free) begin
                        if (r_item.req_type == REQ_RECONNECT) begin
                            r_flag <= 1'b0;
                            r_last <= r_item.now_ms;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    r_item <= i_in_data;
                    r_w    <= i_in_data.want_width;
                    r_h    <= i_in_data.want_height;
                    r_pass <= 1'b0;
                end
            end
            ST_FIT: begin
                r_low <= below;
                if (!div_go) begin
                    r_pass <= 1'b1;
                    // zero dimension below the minimum skips the division
                    if (below) begin
                        if (r_pass) begin
                            r_h <= r_min;
                            r_w <= r_max;
                        end else begin
                            r_w <= r_min;
                            r_h <= r_max;
                        end
                    end
                end
            end
            ST_WAIT: begin
                if (mdu_rsp.done) begin
                    r_pass <= 1'b1;
                    if (r_pass) begin
                        r_h <= res_a;
                        r_w <= res_b;
                    end else begin
                        r_w <= res_a;
                        r_h <= res_b;
                    end
                end
            end
            ST_TRY: begin
                if (out_free) begin
                    r_out.action             <= try_act;
                    r_out.pending_width_out  <= r_pend_w;
                    r_out.pending_height_out <= r_pend_h;
                    r_out.reconnect_flag     <= try_flag;
                end
            end
            ST_MISC: begin
                if (out_free) begin
                    r_out.action             <= ACT_NONE;
                    r_out.pending_width_out  <= r_pend_w;
                    r_out.pending_height_out <= r_pend_h;
                    r_out.reconnect_flag     <= (r_item.req_type == REQ_RECONNECT)
                                                ? 1'b0 : r_flag;
                end
            end
            default: begin
            end
        endcase
    end

    a_pend_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pend_w[0])
        else $error("pending width is odd");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mdu_rsp.done |-> r_state == ST_WAIT)
        else $error("divider finished outside the wait state");

    a_reconnect_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.action == ACT_RECONNECT)
            |-> o_out_data.reconnect_flag)
        else $error("reconnect beat without reconnect flag");

    a_layout_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.action == ACT_LAYOUT)
            |-> (o_out_data.pending_width_out != '0
                 && o_out_data.pending_height_out != '0))
        else $error("layout beat with an empty pending size");

endmodule
